@@ rtl/core/rult_pkg.sv @@
// Shared types and command codes for the unstable log tracker.
// No dependencies; used by the controller, the datapath and the top level.
package rult_pkg;

  localparam int unsigned IDX_W = 64;
  localparam int unsigned CMD_W = 3;

  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STABLE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SNAP_ST = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESTORE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;   // capture item, start index subtract
    logic look;   // range compares, slot select, ring read
    logic exec;   // state update, ring write, result capture
  } ctl_t;

endpackage

@@ rtl/core/rult_ctrl.sv @@
// Sequencing state machine for the unstable log tracker.
// Depends on rult_pkg; drives the command struct into rult_dp.
module rult_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output rult_pkg::ctl_t ctl
);

  rult_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rult_pkg::ST_IDLE: if (in_valid) state_nxt = rult_pkg::ST_LOOK;
      rult_pkg::ST_LOOK: state_nxt = rult_pkg::ST_EXEC;
      rult_pkg::ST_EXEC: state_nxt = rult_pkg::ST_OUT;
      rult_pkg::ST_OUT:  if (out_ready) state_nxt = rult_pkg::ST_IDLE;
      default:           state_nxt = rult_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rult_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == rult_pkg::ST_IDLE);
  assign out_valid = (state_r == rult_pkg::ST_OUT);
  assign ctl.load  = in_ready && in_valid;
  assign ctl.look  = (state_r == rult_pkg::ST_LOOK);
  assign ctl.exec  = (state_r == rult_pkg::ST_EXEC);

endmodule

@@ rtl/core/rult_dp.sv @@
// Datapath of the unstable log tracker: log pointers, snapshot marker,
// term ring memory and result registers. Depends on rult_pkg.
module rult_dp #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rult_pkg::ctl_t             ctl,
  input  logic [rult_pkg::CMD_W-1:0] in_cmd,
  input  logic [rult_pkg::IDX_W-1:0] in_index,
  input  logic [rult_pkg::IDX_W-1:0] in_term,
  output logic [rult_pkg::IDX_W-1:0] out_term_out,
  output logic                       out_term_found,
  output logic [rult_pkg::IDX_W-1:0] out_first_index,
  output logic                       out_first_known,
  output logic [rult_pkg::IDX_W-1:0] out_last_index,
  output logic                       out_last_known,
  output logic                       out_overflow
);

  localparam int unsigned W  = rult_pkg::IDX_W;
  localparam int unsigned SW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam logic [CW:0]   DEPTH_S = (CW+1)'(RING_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

  // head + offset, offset never above the depth: one conditional subtract
  function automatic logic [SW-1:0] wrap(input logic [CW:0] s);
    logic [CW:0] t;
    t = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
    return t[SW-1:0];
  endfunction

  // architectural state
  logic [W-1:0]  base_r;
  logic [CW-1:0] count_r;
  logic [SW-1:0] head_r;
  logic          snap_p_r;
  logic [W-1:0]  snap_idx_r;
  logic [W-1:0]  snap_trm_r;

  logic [W-1:0] term_ring [RING_DEPTH];

  // item and lookup pipeline registers
  logic [rult_pkg::CMD_W-1:0] cmd_r;
  logic [W-1:0]  idx_r, trm_r, off_r;
  logic          ge_r, le_r;
  logic          in_ring_r, at_end_r, snap_hit_r;
  logic [SW-1:0] rslot_r, wslot_r;
  logic [W-1:0]  rdata_r;

  logic [W-1:0]  term_out_r;
  logic          found_r, ovf_r;

  // lookup stage
  logic          in_ring_nxt;
  logic [SW-1:0] rslot_nxt;
  assign in_ring_nxt = ge_r && (off_r < W'(count_r));
  assign rslot_nxt   = wrap((CW+1)'(head_r) + (CW+1)'(off_r[CW-1:0]));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      idx_r <= in_index;
      trm_r <= in_term;
      off_r <= in_index - base_r;
      ge_r  <= in_index >= base_r;
      le_r  <= in_index <= base_r;
    end
    if (ctl.look) begin
      in_ring_r  <= in_ring_nxt;
      at_end_r   <= ge_r && (off_r == W'(count_r));
      snap_hit_r <= snap_p_r && (snap_idx_r == idx_r) && (!ge_r || count_r == '0);
      rslot_r    <= rslot_nxt;
      wslot_r    <= wrap((CW+1)'(head_r) + (CW+1)'(count_r));
      rdata_r    <= term_ring[rslot_nxt];
    end
  end

  // execute stage
  logic          found_nxt;
  logic [W-1:0]  fterm_nxt;
  logic          ovf_nxt;
  logic [W-1:0]  base_nxt;
  logic [CW-1:0] count_nxt;
  logic [SW-1:0] head_nxt;
  logic          snap_p_nxt;
  logic [W-1:0]  snap_idx_nxt, snap_trm_nxt;
  logic          we;
  logic [SW-1:0] waddr;
  logic [CW-1:0] off_inc;

  assign off_inc   = off_r[CW-1:0] + CW'(1);
  assign found_nxt = in_ring_r || snap_hit_r;
  assign fterm_nxt = in_ring_r ? rdata_r : (snap_hit_r ? snap_trm_r : '0);

  always_comb begin
    base_nxt     = base_r;
    count_nxt    = count_r;
    head_nxt     = head_r;
    snap_p_nxt   = snap_p_r;
    snap_idx_nxt = snap_idx_r;
    snap_trm_nxt = snap_trm_r;
    ovf_nxt      = 1'b0;
    we           = 1'b0;
    waddr        = wslot_r;
    unique case (cmd_r)
      rult_pkg::CMD_STABLE: begin
        if (in_ring_r && rdata_r == trm_r) begin
          head_nxt  = wrap((CW+1)'(rslot_r) + (CW+1)'(1));
          count_nxt = count_r - off_inc;
          base_nxt  = idx_r + W'(1);
        end
      end
      rult_pkg::CMD_SNAP_ST: begin
        if (snap_p_r && snap_idx_r == idx_r) snap_p_nxt = 1'b0;
      end
      rult_pkg::CMD_RESTORE: begin
        snap_p_nxt   = 1'b1;
        snap_idx_nxt = idx_r;
        snap_trm_nxt = trm_r;
        base_nxt     = idx_r + W'(1);
        count_nxt    = '0;
        head_nxt     = '0;
      end
      rult_pkg::CMD_APPEND: begin
        priority if (at_end_r) begin
          if (count_r == DEPTH_C) begin
            ovf_nxt = 1'b1;
          end else begin
            we        = 1'b1;
            waddr     = wslot_r;
            count_nxt = count_r + CW'(1);
          end
        end else if (le_r) begin
          // replaces the whole ring with this one entry
          base_nxt  = idx_r;
          head_nxt  = '0;
          we        = 1'b1;
          waddr     = '0;
          count_nxt = CW'(1);
        end else if (in_ring_r) begin
          // overwrite this entry and truncate the tail after it
          we        = 1'b1;
          waddr     = rslot_r;
          count_nxt = off_inc;
        end else begin
          ovf_nxt = 1'b0;
        end
      end
      default: begin
        ovf_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && we) begin
      term_ring[waddr] <= trm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      term_out_r <= fterm_nxt;
      found_r    <= found_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      count_r    <= '0;
      head_r     <= '0;
      snap_p_r   <= 1'b1;
      snap_idx_r <= '0;
      snap_trm_r <= '0;
    end else if (ctl.exec) begin
      base_r     <= base_nxt;
      count_r    <= count_nxt;
      head_r     <= head_nxt;
      snap_p_r   <= snap_p_nxt;
      snap_idx_r <= snap_idx_nxt;
      snap_trm_r <= snap_trm_nxt;
    end
  end

  // state is frozen while a result waits, so these read it directly
  assign out_term_out    = term_out_r;
  assign out_term_found  = found_r;
  assign out_overflow    = ovf_r;
  assign out_first_known = snap_p_r;
  assign out_first_index = snap_p_r ? (snap_idx_r + W'(1)) : '0;
  assign out_last_known  = (count_r != '0) || snap_p_r;
  assign out_last_index  = (count_r != '0) ? (base_r + W'(count_r) - W'(1)) :
                           (snap_p_r ? snap_idx_r : '0);

endmodule

@@ rtl/core/raft_unstable_log_tracker_unit.sv @@
// Top level of the unstable log tracker: controller plus datapath.
// Depends on rult_pkg, rult_ctrl and rult_dp.
//
// Usage:
//   Input channel in_valid/in_ready carries one command (in_cmd) with an
//   index and a term. Result channel out_valid/out_ready carries one result
//   per command: the term at the index before the update, and the first and
//   last log index after it, plus an overflow flag for a dropped append.
//   Commands: term lookup, stable-to, snapshot stable, restore snapshot,
//   append entry; other codes act as a lookup.
//   Sequencing: one item at a time, stepped through the load / ring-read /
//   update / output sequence of the controller around the single-port
//   term ring; the result is valid in the output state.
//   Reset (rst_n low, synchronous): empty ring, base index 0, snapshot
//   marker present at index 0 with term 0. Ring contents are not cleared;
//   only data read from live slots is ever used.
//   When the receiver stalls, the result and all state hold and no new
//   item is taken until the result transfer completes.
module raft_unstable_log_tracker_unit #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [63:0] in_index,
  input  logic [63:0] in_term,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_term_out,
  output logic        out_term_found,
  output logic [63:0] out_first_index,
  output logic        out_first_known,
  output logic [63:0] out_last_index,
  output logic        out_last_known,
  output logic        out_overflow
);

  rult_pkg::ctl_t ctl;

  rult_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  rult_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .in_cmd          (in_cmd),
    .in_index        (in_index),
    .in_term         (in_term),
    .out_term_out    (out_term_out),
    .out_term_found  (out_term_found),
    .out_first_index (out_first_index),
    .out_first_known (out_first_known),
    .out_last_index  (out_last_index),
    .out_last_known  (out_last_known),
    .out_overflow    (out_overflow)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##3 out_valid)
    else $error("result not presented three cycles after input transfer");

  a_first_implies_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_first_known) |-> out_last_known)
    else $error("snapshot marker present but last index unknown");

  a_overflow_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_last_known && !out_term_found))
    else $error("overflow reported with empty log or a found term");

endmodule
